// ----- hw/rtl/v2alu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2alu_pkg
// Shared types, codes and widths of the two-dimensional fixed-point vector unit.
// ----------------------------------------------------------------------------
package v2alu_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 16;
    localparam int SQ_BITS       = 2 * WORD_BITS + 1;
    localparam int ROOT_BITS     = WORD_BITS + 1;
    localparam int NUM_BITS      = WORD_BITS + FRACTION_BITS;
    localparam int DEPTH         = ROOT_BITS + NUM_BITS + 4;

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_SCALE = 3'd2,
        FN_LENGTH = 3'd3,
        FN_NORM = 3'd4
    } t_func;

    typedef struct packed {
        logic [2:0]                  func;
        logic signed [WORD_BITS-1:0] ax;
        logic signed [WORD_BITS-1:0] ay;
        logic signed [WORD_BITS-1:0] bx;
        logic signed [WORD_BITS-1:0] by;
        logic signed [WORD_BITS-1:0] factor;
    } t_in;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] rx;
        logic signed [WORD_BITS-1:0] ry;
        logic [WORD_BITS-2:0]        magnitude;
        logic                        overflow;
        logic                        zero_vector;
    } t_out;

    // Saturate a sign plus magnitude to the signed word range.
    function automatic logic [WORD_BITS:0] sign_sat(input logic [NUM_BITS-1:0] mag,
                                                    input logic neg);
        logic [NUM_BITS-1:0] lim;
        logic [WORD_BITS-1:0] m;
        logic ov;
        lim = neg ? (NUM_BITS'(1) << (WORD_BITS-1)) : ((NUM_BITS'(1) << (WORD_BITS-1)) - 1'b1);
        ov  = mag > lim;
        m   = ov ? lim[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
        return {ov, neg ? (~m + 1'b1) : m};
    endfunction

endpackage

// ----- hw/rtl/v2alu_sqrt_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2alu_sqrt_stage
// One restoring square-root step: decide one root bit per cycle.
// ----------------------------------------------------------------------------
module v2alu_sqrt_stage
    import v2alu_pkg::*;
(
    input  logic                 i_clk,
    input  logic [SQ_BITS-1:0]   i_rem,
    input  logic [ROOT_BITS-1:0] i_root,
    input  logic [1:0]           i_pair,
    output logic [SQ_BITS-1:0]   o_rem,
    output logic [ROOT_BITS-1:0] o_root
);
    logic [SQ_BITS-1:0] n_rem, trial;
    assign n_rem = {i_rem[SQ_BITS-3:0], i_pair};
    assign trial = {{(SQ_BITS-ROOT_BITS-2){1'b0}}, i_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (n_rem >= trial) begin
            o_rem  <= n_rem - trial;
            o_root <= {i_root[ROOT_BITS-2:0], 1'b1};
        end else begin
            o_rem  <= n_rem;
            o_root <= {i_root[ROOT_BITS-2:0], 1'b0};
        end
    end
endmodule

// ----- hw/rtl/v2alu_div_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2alu_div_lane
// One component lane: pipelined restoring divide of |a| << FRACTION_BITS by
// the length, one quotient bit per stage.
// ----------------------------------------------------------------------------
module v2alu_div_lane
    import v2alu_pkg::*;
(
    input  logic                 i_clk,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [ROOT_BITS-1:0] i_den,
    output logic [NUM_BITS-1:0]  o_quo
);
    logic [ROOT_BITS:0]   r_rem [NUM_BITS+1];
    logic [NUM_BITS-1:0]  r_num [NUM_BITS+1];
    logic [ROOT_BITS-1:0] r_den [NUM_BITS+1];

    assign r_rem[0] = '0;
    assign r_num[0] = i_num;
    assign r_den[0] = i_den;

    for (genvar k = 0; k < NUM_BITS; k++) begin : g_step
        logic [ROOT_BITS:0] sh;
        assign sh = {r_rem[k][ROOT_BITS-1:0], r_num[k][NUM_BITS-1]};
        always_ff @(posedge i_clk) begin
            r_den[k+1] <= r_den[k];
            if (sh >= {1'b0, r_den[k]}) begin
                r_rem[k+1] <= sh - {1'b0, r_den[k]};
                r_num[k+1] <= {r_num[k][NUM_BITS-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= sh;
                r_num[k+1] <= {r_num[k][NUM_BITS-2:0], 1'b0};
            end
        end
    end
    assign o_quo = r_num[NUM_BITS];
endmodule

// ----- hw/rtl/vec2_fixed_point_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec2_fixed_point_alu
// Two-dimensional Q16.16 vector unit: add, subtract, scale, length, normalize.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_in and raise start; an item transfers at each rising edge where
//   start is high and busy is low. busy is always low: the unit takes one
//   item every clock, back to back.
//   Every item yields exactly one result on o_out, marked by o_strobe for one
//   cycle, in order. Results of all operations leave at the same latency.
//   Latency is set by the square-root pipeline (one root bit per stage)
//   followed by the divide lanes (one quotient bit per stage).
//   The receiver cannot stall; results are not held.
//   Reset (i_rst_n low, synchronous) clears the valid pipeline, so no
//   strobe appears for items in flight.
// ----------------------------------------------------------------------------
module vec2_fixed_point_alu
    import v2alu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_in,
    output logic o_strobe,
    output t_out o_out
);
    localparam int SQ_STG = ROOT_BITS;
    localparam int TOT    = 1 + SQ_STG + NUM_BITS;

    assign busy = 1'b0;

    // Stage 0: register the item and take the magnitudes of ax, ay and factor.
    t_in r_in;
    logic r_v0;
    always_ff @(posedge i_clk) begin
        r_in <= i_in;
        if (!i_rst_n) r_v0 <= 1'b0;
        else r_v0 <= start;
    end

    logic [WORD_BITS-1:0] abx, aby, abf;
    assign abx = r_in.ax[WORD_BITS-1] ? WORD_BITS'(-r_in.ax) : r_in.ax;
    assign aby = r_in.ay[WORD_BITS-1] ? WORD_BITS'(-r_in.ay) : r_in.ay;
    assign abf = r_in.factor[WORD_BITS-1] ? WORD_BITS'(-r_in.factor) : r_in.factor;

    // Stage 1: products, one multiplier each.
    logic [2*WORD_BITS-1:0] r_sqx, r_sqy, r_px, r_py;
    t_in  r_in1;
    logic r_v1;
    always_ff @(posedge i_clk) begin
        r_sqx <= abx * abx;
        r_sqy <= aby * aby;
        r_px  <= abx * abf;
        r_py  <= aby * abf;
        r_in1 <= r_in;
        if (!i_rst_n) r_v1 <= 1'b0;
        else r_v1 <= r_v0;
    end

    // Immediate result of add, subtract and scale; delayed alongside.
    t_out imm;
    always_comb begin
        logic signed [WORD_BITS:0] sx, sy;
        logic [WORD_BITS:0] tx, ty;
        logic [NUM_BITS-1:0] mx, my;
        logic sgnf;
        imm = '0;
        sgnf = r_in1.factor[WORD_BITS-1];
        mx = '0;
        my = '0;
        sx = '0;
        sy = '0;
        tx = '0;
        ty = '0;
        unique case (r_in1.func)
            FN_ADD, FN_SUB: begin
                if (r_in1.func == FN_ADD) begin
                    sx = {r_in1.ax[WORD_BITS-1], r_in1.ax} + {r_in1.bx[WORD_BITS-1], r_in1.bx};
                    sy = {r_in1.ay[WORD_BITS-1], r_in1.ay} + {r_in1.by[WORD_BITS-1], r_in1.by};
                end else begin
                    sx = {r_in1.ax[WORD_BITS-1], r_in1.ax} - {r_in1.bx[WORD_BITS-1], r_in1.bx};
                    sy = {r_in1.ay[WORD_BITS-1], r_in1.ay} - {r_in1.by[WORD_BITS-1], r_in1.by};
                end
                imm.rx = (sx[WORD_BITS] != sx[WORD_BITS-1]) ?
                         {sx[WORD_BITS], {(WORD_BITS-1){~sx[WORD_BITS]}}} : sx[WORD_BITS-1:0];
                imm.ry = (sy[WORD_BITS] != sy[WORD_BITS-1]) ?
                         {sy[WORD_BITS], {(WORD_BITS-1){~sy[WORD_BITS]}}} : sy[WORD_BITS-1:0];
                imm.overflow = (sx[WORD_BITS] != sx[WORD_BITS-1]) ||
                               (sy[WORD_BITS] != sy[WORD_BITS-1]);
            end
            FN_SCALE: begin
                mx = (r_px[2*WORD_BITS-1:FRACTION_BITS] > {NUM_BITS{1'b1}}) ? '1 :
                     NUM_BITS'(r_px >> FRACTION_BITS);
                my = (r_py[2*WORD_BITS-1:FRACTION_BITS] > {NUM_BITS{1'b1}}) ? '1 :
                     NUM_BITS'(r_py >> FRACTION_BITS);
                tx = sign_sat(mx, (r_in1.ax[WORD_BITS-1] != sgnf) && (mx != 0));
                ty = sign_sat(my, (r_in1.ay[WORD_BITS-1] != sgnf) && (my != 0));
                imm.rx = tx[WORD_BITS-1:0];
                imm.ry = ty[WORD_BITS-1:0];
                imm.overflow = tx[WORD_BITS] | ty[WORD_BITS];
            end
            default: imm = '0;
        endcase
    end

    // Stage 2: sum of squares.
    logic [SQ_BITS-1:0] r_sum;
    t_in  r_in2;
    t_out r_imm2;
    logic r_v2;
    always_ff @(posedge i_clk) begin
        r_sum  <= {1'b0, r_sqx} + {1'b0, r_sqy};
        r_in2  <= r_in1;
        r_imm2 <= imm;
        if (!i_rst_n) r_v2 <= 1'b0;
        else r_v2 <= r_v1;
    end

    // Square-root pipeline: the operand shifts out two bits per stage.
    logic [SQ_BITS-1:0]   sq_rem [SQ_STG+1];
    logic [ROOT_BITS-1:0] sq_root[SQ_STG+1];
    logic [2*SQ_STG-1:0]  sq_opd [SQ_STG+1];
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_opd[0]  = (2*SQ_STG)'(r_sum);

    for (genvar s = 0; s < SQ_STG; s++) begin : g_sqrt
        v2alu_sqrt_stage u_stage (
            .i_clk  (i_clk),
            .i_rem  (sq_rem[s]),
            .i_root (sq_root[s]),
            .i_pair (sq_opd[s][2*SQ_STG-1 -: 2]),
            .o_rem  (sq_rem[s+1]),
            .o_root (sq_root[s+1])
        );
        always_ff @(posedge i_clk) begin
            sq_opd[s+1] <= {sq_opd[s][2*SQ_STG-3:0], 2'b00};
        end
    end

    // Side pipeline for item info through sqrt and divide.
    t_in  r_dl_in  [TOT-1];
    t_out r_dl_imm [TOT-1];
    logic r_dl_v   [TOT-1];
    always_ff @(posedge i_clk) begin
        r_dl_in[0]  <= r_in2;
        r_dl_imm[0] <= r_imm2;
        for (int k = 1; k < TOT-1; k++) begin
            r_dl_in[k]  <= r_dl_in[k-1];
            r_dl_imm[k] <= r_dl_imm[k-1];
        end
        if (!i_rst_n) begin
            for (int k = 0; k < TOT-1; k++) r_dl_v[k] <= 1'b0;
        end else begin
            r_dl_v[0] <= r_v2;
            for (int k = 1; k < TOT-1; k++) r_dl_v[k] <= r_dl_v[k-1];
        end
    end

    // Divide lanes, one per component.
    t_in sq_in;
    assign sq_in = r_dl_in[SQ_STG-1];
    logic [WORD_BITS-1:0] dax, day;
    assign dax = sq_in.ax[WORD_BITS-1] ? WORD_BITS'(-sq_in.ax) : sq_in.ax;
    assign day = sq_in.ay[WORD_BITS-1] ? WORD_BITS'(-sq_in.ay) : sq_in.ay;
    logic [ROOT_BITS-1:0] root;
    assign root = sq_root[SQ_STG];

    logic [NUM_BITS-1:0] qx, qy;
    v2alu_div_lane u_lane_x (
        .i_clk (i_clk),
        .i_num ({dax, {FRACTION_BITS{1'b0}}}),
        .i_den (root),
        .o_quo (qx)
    );
    v2alu_div_lane u_lane_y (
        .i_clk (i_clk),
        .i_num ({day, {FRACTION_BITS{1'b0}}}),
        .i_den (root),
        .o_quo (qy)
    );

    logic [ROOT_BITS-1:0] r_len [NUM_BITS];
    always_ff @(posedge i_clk) begin
        r_len[0] <= root;
        for (int k = 1; k < NUM_BITS; k++) r_len[k] <= r_len[k-1];
    end

    // Merge: pick the result by operation.
    t_in  m_in;
    t_out m_imm, n_out;
    logic [ROOT_BITS-1:0] len;
    assign m_in  = r_dl_in[TOT-2];
    assign m_imm = r_dl_imm[TOT-2];
    assign len   = r_len[NUM_BITS-1];
    always_comb begin
        logic [WORD_BITS:0] tx, ty;
        logic movf;
        n_out = m_imm;
        movf  = len[ROOT_BITS-1] | len[ROOT_BITS-2];
        tx = sign_sat(qx, m_in.ax[WORD_BITS-1]);
        ty = sign_sat(qy, m_in.ay[WORD_BITS-1]);
        if (m_in.func == FN_LENGTH) begin
            n_out = '0;
            n_out.magnitude = movf ? '1 : len[WORD_BITS-2:0];
            n_out.overflow  = movf;
        end else if (m_in.func == FN_NORM) begin
            n_out = '0;
            if (len == '0) begin
                n_out.zero_vector = 1'b1;
            end else begin
                n_out.magnitude = movf ? '1 : len[WORD_BITS-2:0];
                n_out.rx = tx[WORD_BITS-1:0];
                n_out.ry = ty[WORD_BITS-1:0];
                n_out.overflow = movf | tx[WORD_BITS] | ty[WORD_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_out <= n_out;
        if (!i_rst_n) o_strobe <= 1'b0;
        else o_strobe <= r_dl_v[TOT-2];
    end
endmodule

// ----- tb/vec2_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec2_result_checker
// Watches both channels of the vector unit, predicts each result and compares.
// ----------------------------------------------------------------------------
module vec2_result_checker
    import v2alu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic busy,
    input  t_in  i_in,
    input  logic o_strobe,
    input  t_out o_out,
    output int   o_fails,
    output int   o_pending,
    output int   o_checked
);

    t_out expected_results[$];

    // Magnitude of a signed word as an unsigned word (the minimum maps to 2^31).
    function automatic logic [WORD_BITS-1:0] abs_word(input logic [WORD_BITS-1:0] v);
        return v[WORD_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    // Attach a sign to a magnitude, clamp to the word range; top bit is the clamp flag.
    function automatic logic [WORD_BITS:0] clamp_signed(input logic [63:0] mag,
                                                        input logic neg);
        logic [63:0] lim;
        logic [WORD_BITS-1:0] w;
        logic hit;
        lim = neg ? (64'd1 << (WORD_BITS-1)) : ((64'd1 << (WORD_BITS-1)) - 64'd1);
        hit = mag > lim;
        w   = hit ? lim[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
        return {hit, neg ? (~w + 1'b1) : w};
    endfunction

    function automatic logic [WORD_BITS:0] add_clamped(input logic [WORD_BITS:0] s);
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return {1'b1, s[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                       : {1'b0, {(WORD_BITS-1){1'b1}}}};
        return {1'b0, s[WORD_BITS-1:0]};
    endfunction

    function automatic t_out predict_vector_result(input t_in x);
        t_out r;
        logic [WORD_BITS:0] cx, cy;
        logic [63:0] pa, pb;
        logic [65:0] sumsq, sq;
        logic [32:0] root, cand;
        logic [63:0] qx, qy;
        r = '0;
        case (x.func)
            FN_ADD, FN_SUB: begin
                if (x.func == FN_ADD) begin
                    cx = add_clamped({x.ax[31], x.ax} + {x.bx[31], x.bx});
                    cy = add_clamped({x.ay[31], x.ay} + {x.by[31], x.by});
                end else begin
                    cx = add_clamped({x.ax[31], x.ax} - {x.bx[31], x.bx});
                    cy = add_clamped({x.ay[31], x.ay} - {x.by[31], x.by});
                end
                r.rx = cx[WORD_BITS-1:0];
                r.ry = cy[WORD_BITS-1:0];
                r.overflow = cx[WORD_BITS] | cy[WORD_BITS];
            end
            FN_SCALE: begin
                pa = 64'(abs_word(x.ax)) * 64'(abs_word(x.factor));
                pb = 64'(abs_word(x.ay)) * 64'(abs_word(x.factor));
                cx = clamp_signed(pa >> FRACTION_BITS, x.ax[31] ^ x.factor[31]);
                cy = clamp_signed(pb >> FRACTION_BITS, x.ay[31] ^ x.factor[31]);
                r.rx = cx[WORD_BITS-1:0];
                r.ry = cy[WORD_BITS-1:0];
                r.overflow = cx[WORD_BITS] | cy[WORD_BITS];
            end
            FN_LENGTH, FN_NORM: begin
                pa = 64'(abs_word(x.ax)) * 64'(abs_word(x.ax));
                pb = 64'(abs_word(x.ay)) * 64'(abs_word(x.ay));
                sumsq = 66'(pa) + 66'(pb);
                // Restore the root one bit at a time, top bit first.
                root = '0;
                for (int i = 32; i >= 0; i--) begin
                    cand = root | (33'd1 << i);
                    sq = 66'(cand) * 66'(cand);
                    if (sq <= sumsq) root = cand;
                end
                if (x.func == FN_NORM && root == 0) begin
                    r.zero_vector = 1'b1;
                end else begin
                    if (root > 33'h7FFF_FFFF) begin
                        r.magnitude = '1;
                        r.overflow  = 1'b1;
                    end else begin
                        r.magnitude = root[WORD_BITS-2:0];
                    end
                    if (x.func == FN_NORM) begin
                        qx = (64'(abs_word(x.ax)) << FRACTION_BITS) / 64'(root);
                        qy = (64'(abs_word(x.ay)) << FRACTION_BITS) / 64'(root);
                        cx = clamp_signed(qx, x.ax[31]);
                        cy = clamp_signed(qy, x.ay[31]);
                        r.rx = cx[WORD_BITS-1:0];
                        r.ry = cy[WORD_BITS-1:0];
                        r.overflow = r.overflow | cx[WORD_BITS] | cy[WORD_BITS];
                    end
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            o_fails   <= 0;
            o_checked <= 0;
        end else begin
            if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result rx=%h ry=%h mag=%h ovf=%b zv=%b", $time,
                             o_out.rx, o_out.ry, o_out.magnitude, o_out.overflow,
                             o_out.zero_vector);
                    o_fails <= o_fails + 1;
                end else begin
                    want = expected_results.pop_front();
                    o_checked <= o_checked + 1;
                    if (want.rx !== o_out.rx || want.ry !== o_out.ry ||
                        want.magnitude !== o_out.magnitude ||
                        want.overflow !== o_out.overflow ||
                        want.zero_vector !== o_out.zero_vector) begin
                        $display("%0t: mismatch expected rx=%h ry=%h mag=%h ovf=%b zv=%b",
                                 $time, want.rx, want.ry, want.magnitude, want.overflow,
                                 want.zero_vector);
                        $display("%0t:          actual   rx=%h ry=%h mag=%h ovf=%b zv=%b",
                                 $time, o_out.rx, o_out.ry, o_out.magnitude,
                                 o_out.overflow, o_out.zero_vector);
                        o_fails <= o_fails + 1;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(predict_vector_result(i_in));
        end
    end

endmodule

// ----- tb/vec2_fixed_point_alu_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec2_fixed_point_alu_tb
// Drives directed corner cases and random vector operations into the unit
// with random gaps; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module vec2_fixed_point_alu_tb;
    import v2alu_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_in = '0;
    logic o_strobe;
    t_out o_out;

    int fails, pending, checked;
    int cycles = 0;
    int sent = 0;
    int op_count[8];

    always #5 i_clk = ~i_clk;

    vec2_fixed_point_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_strobe(o_strobe),
        .o_out   (o_out)
    );

    vec2_result_checker checker_inst (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_strobe (o_strobe),
        .o_out    (o_out),
        .o_fails  (fails),
        .o_pending(pending),
        .o_checked(checked)
    );

    // Watchdog: abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Mix full-range words with small values and the extremes.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h1_FFFF;
            1: begin
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0000_0001;
                    4: return 32'h0001_0000;
                    default: return 32'h0;
                endcase
            end
            2: return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h007F_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Present one item with the given gap in front of it; hold start high
    // across back-to-back transfers, and return on the edge that takes it.
    task automatic send_item(input t_in x, input int gap);
        logic was_busy;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= x;
        op_count[x.func] = op_count[x.func] + 1;
        sent = sent + 1;
        do begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
        end while (was_busy);
    endtask

    task automatic send_fields(input logic [2:0] f, input logic [31:0] ax,
                               input logic [31:0] ay, input logic [31:0] bx,
                               input logic [31:0] by, input logic [31:0] k);
        t_in x;
        x.func = f; x.ax = ax; x.ay = ay; x.bx = bx; x.by = by; x.factor = k;
        send_item(x, $urandom_range(0, 3));
    endtask

    initial begin
        t_in x;
        int gap;
        bit burst;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners: add, subtract and scale, with and without saturation.
        send_fields(FN_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_fields(FN_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_0001, 0);
        send_fields(FN_SUB, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
        send_fields(FN_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 0);
        send_fields(FN_SCALE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000);
        send_fields(FN_SCALE, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 32'h0001_0000);
        send_fields(FN_SCALE, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 32'h0000_0001);
        send_fields(FN_SCALE, 32'h0012_3456, 32'hFFED_CBAA, 0, 0, 32'hFFFF_8000);
        // Length: zero, a 3-4-5 vector, the widest vector (magnitude clamps) and the widest single axis.
        send_fields(FN_LENGTH, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(FN_LENGTH, 32'h0003_0000, 32'hFFFC_0000, 0, 0, 0);
        send_fields(FN_LENGTH, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        send_fields(FN_LENGTH, 32'h7FFF_FFFF, 32'h0, 0, 0, 0);
        // Normalize: zero vector flag, tiny and huge inputs.
        send_fields(FN_NORM, 32'h0, 32'h0, 0, 0, 0);
        send_fields(FN_NORM, 32'h0000_0001, 32'h0, 0, 0, 0);
        send_fields(FN_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        send_fields(FN_NORM, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        send_fields(FN_NORM, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0);
        // Undefined operation codes give all zeros.
        send_fields(3'd5, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF);
        send_fields(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_fields(3'd7, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);

        // Drain everything before the random part.
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        burst = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            x.func   = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4));
            x.ax     = pick_word();
            x.ay     = pick_word();
            x.bx     = pick_word();
            x.by     = pick_word();
            x.factor = pick_word();
            // Alternate between back-to-back bursts and random gaps.
            if ($urandom_range(0, 49) == 0) burst = ~burst;
            gap = burst ? 0 : $urandom_range(0, 15);
            send_item(x, gap);
            // Hold off once mid-run until the pipeline is empty.
            if (n == RANDOM_ITEMS / 2) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DEPTH + 20) @(posedge i_clk);

        $display("Covered %0d transfers, %0d results checked: add %0d sub %0d scale %0d",
                 sent, checked, op_count[FN_ADD], op_count[FN_SUB], op_count[FN_SCALE]);
        $display("  length %0d normalize %0d undefined codes %0d",
                 op_count[FN_LENGTH], op_count[FN_NORM],
                 op_count[5] + op_count[6] + op_count[7]);
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
